// ===== rtl/periodic_tick_scheduler_macros.svh =====
// ----------------------------------------------------------------------------
// periodic_tick_scheduler_macros
// Assertion helpers for the scheduler datapath. They sample on clk and are
// disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TICK_SCHEDULER_MACROS_SVH
`define PERIODIC_TICK_SCHEDULER_MACROS_SVH

// Same-cycle implication.
`define PTS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pts assertion failed");

// Next-cycle implication.
`define PTS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pts assertion failed");

`endif

// ===== rtl/pts_pkg.sv =====
// ----------------------------------------------------------------------------
// pts_pkg
// Widths, codes and controller/datapath types for the periodic tick scheduler.
// ----------------------------------------------------------------------------
package pts_pkg;

	localparam int SLOTS_DEF = 16;
	localparam int MAX_OUT   = 16;

	localparam int OP_W   = 2;
	localparam int ID_W   = 16;
	localparam int PER_W  = 16;
	localparam int TIME_W = 32;
	localparam int ST_W   = 3;
	localparam int SLOT_W = 4;
	localparam int CD_W   = 17;

	localparam logic [OP_W-1:0] OP_POLL   = 2'd0;
	localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

	localparam logic [ST_W-1:0] ST_FIRED   = 3'd0;
	localparam logic [ST_W-1:0] ST_ADDED   = 3'd1;
	localparam logic [ST_W-1:0] ST_PRESENT = 3'd2;
	localparam logic [ST_W-1:0] ST_FULL    = 3'd3;
	localparam logic [ST_W-1:0] ST_REMOVED = 3'd4;
	localparam logic [ST_W-1:0] ST_ABSENT  = 3'd5;
	localparam logic [ST_W-1:0] ST_NULL_ID = 3'd6;

	// Controller to datapath.
	typedef struct packed {
		logic cap;     // take the request in
		logic walk;    // sweep the slot table
		logic finish;  // resolve add or remove, write back
		logic flush;   // push the held result out as last
	} pts_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic kind_walk;
		logic kind_null;
		logic walk_done;
		logic hold_v;
		logic out_free;
	} pts_sts_t;

endpackage

// ===== rtl/pts_if.sv =====
// ----------------------------------------------------------------------------
// pts_if
// Valid/ready channels of the scheduler: request in, result out.
// ----------------------------------------------------------------------------
interface pts_req_if import pts_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   op;
	logic [ID_W-1:0]   client_id;
	logic [PER_W-1:0]  period;
	logic [TIME_W-1:0] now_ms;

	modport source (output valid, output op, output client_id, output period,
		output now_ms, input ready);
	modport sink (input valid, input op, input client_id, input period,
		input now_ms, output ready);
endinterface

interface pts_res_if import pts_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ST_W-1:0]   status;
	logic [SLOT_W-1:0] slot;
	logic [ID_W-1:0]   fired_id;
	logic              last;

	modport source (output valid, output status, output slot, output fired_id,
		output last, input ready);
	modport sink (input valid, input status, input slot, input fired_id,
		input last, output ready);
endinterface

// ===== rtl/pts_ctrl.sv =====
// ----------------------------------------------------------------------------
// pts_ctrl
// Sequencer: accept, sweep the table, resolve, flush the last result.
// ----------------------------------------------------------------------------
module pts_ctrl import pts_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	input  pts_sts_t sts,
	output logic     req_ready,
	output pts_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_FINISH,
		S_FLUSH
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						if (sts.kind_walk) begin
							state_q <= S_WALK;
						end else if (sts.kind_null) begin
							state_q <= S_FINISH;
						end
					end
				end
				S_WALK: begin
					if (sts.walk_done) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					state_q <= S_FLUSH;
				end
				S_FLUSH: begin
					if (!sts.hold_v || sts.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req_ready  = (state_q == S_IDLE);
	assign cmd.cap    = (state_q == S_IDLE) && req_valid;
	assign cmd.walk   = (state_q == S_WALK);
	assign cmd.finish = (state_q == S_FINISH);
	assign cmd.flush  = (state_q == S_FLUSH);

endmodule

// ===== rtl/pts_dp.sv =====
// ----------------------------------------------------------------------------
// pts_dp
// Slot table memories, sweep pipeline, search trackers, result hold and
// output register.
// ----------------------------------------------------------------------------
`include "periodic_tick_scheduler_macros.svh"

module pts_dp import pts_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  pts_cmd_t          cmd,
	output pts_sts_t          sts,
	input  logic [OP_W-1:0]   req_op,
	input  logic [ID_W-1:0]   req_id,
	input  logic [PER_W-1:0]  req_period,
	input  logic [TIME_W-1:0] req_now,
	pts_res_if.source         rsp
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(MAX_OUT + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

	// slot table
	logic [ID_W-1:0]  mem_id  [SLOTS];
	logic [PER_W-1:0] mem_per [SLOTS];
	logic [CD_W-1:0]  mem_cd  [SLOTS];
	logic [SLOTS-1:0] vld_ip_q;
	logic [SLOTS-1:0] vld_cd_q;

	// captured request
	logic [OP_W-1:0]   op_q;
	logic [ID_W-1:0]   id_q;
	logic [PER_W-1:0]  per_q;
	logic [TIME_W-1:0] last_time_q;

	// sweep
	logic [IW-1:0]    rd_addr_q;
	logic             rd_busy_q;
	logic             s1_v_q;
	logic [IW-1:0]    idx_s1;
	logic [ID_W-1:0]  id_s1;
	logic [PER_W-1:0] per_s1;
	logic [CD_W-1:0]  cd_s1;

	// search and fire count
	logic          found_q;
	logic [IW-1:0] found_idx_q;
	logic          free_q;
	logic [IW-1:0] free_idx_q;
	logic [CW-1:0] n_q;

	// held result
	logic            hold_v_q;
	logic [ST_W-1:0] hold_status_q;
	logic [IW-1:0]   hold_idx_q;
	logic [ID_W-1:0] hold_id_q;

	// output register
	logic              out_v_q;
	logic [ST_W-1:0]   out_status_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic [ID_W-1:0]   out_id_q;
	logic              out_last_q;

	logic poll_q, addrm_q, out_free, fire_cand, emit, stall, step, rd_go, proc;
	logic                 id_we, per_we, cd_we;
	logic [IW-1:0]        wr_addr;
	logic [ID_W-1:0]      id_wd;
	logic [CD_W-1:0]      cd_wd;
	logic                 res_v;
	logic [ST_W-1:0]      res_status;
	logic [IW-1:0]        res_idx;
	logic [ID_W-1:0]      res_id;
	logic                 push_v;
	logic                 push_last;
	logic [IW+SLOT_W-1:0] hold_idx_ext;
	logic                 req_addrm;

	assign poll_q    = (op_q == OP_POLL);
	assign addrm_q   = (op_q == OP_ADD) || (op_q == OP_REMOVE);
	assign req_addrm = (req_op == OP_ADD) || (req_op == OP_REMOVE);
	assign out_free  = !out_v_q || rsp.ready;
	assign fire_cand = (cd_s1 <= CD_W'(1));
	assign emit      = s1_v_q && poll_q && fire_cand && (id_s1 != '0) && (n_q < CW'(MAX_OUT));
	assign stall     = emit && hold_v_q && !out_free;
	assign step      = cmd.walk && !stall;
	assign rd_go     = step && rd_busy_q;
	assign proc      = step && s1_v_q;

	assign sts.kind_walk = ((req_op == OP_POLL) && (req_now != last_time_q)) ||
		(req_addrm && (req_id != '0));
	assign sts.kind_null = req_addrm && (req_id == '0);
	assign sts.walk_done = !rd_busy_q && !s1_v_q;
	assign sts.hold_v    = hold_v_q;
	assign sts.out_free  = out_free;

	// final result of add, remove or null id
	always_comb begin
		res_v      = 1'b0;
		res_status = ST_NULL_ID;
		res_idx    = '0;
		res_id     = '0;
		if (addrm_q) begin
			res_v = 1'b1;
			if (id_q == '0) begin
				res_status = ST_NULL_ID;
			end else if (op_q == OP_ADD) begin
				res_id = id_q;
				if (found_q) begin
					res_status = ST_PRESENT;
					res_idx    = found_idx_q;
				end else if (free_q) begin
					res_status = ST_ADDED;
					res_idx    = free_idx_q;
				end else begin
					res_status = ST_FULL;
				end
			end else begin
				res_id = id_q;
				if (found_q) begin
					res_status = ST_REMOVED;
					res_idx    = found_idx_q;
				end else begin
					res_status = ST_ABSENT;
				end
			end
		end
	end

	// table write port
	always_comb begin
		id_we   = 1'b0;
		per_we  = 1'b0;
		cd_we   = 1'b0;
		wr_addr = idx_s1;
		id_wd   = id_q;
		cd_wd   = fire_cand ? {1'b0, per_s1} : (cd_s1 - CD_W'(1));
		if (proc && poll_q) begin
			cd_we = 1'b1;
		end else if (cmd.finish && (id_q != '0)) begin
			if (op_q == OP_ADD && !found_q && free_q) begin
				id_we   = 1'b1;
				per_we  = 1'b1;
				cd_we   = 1'b1;
				wr_addr = free_idx_q;
				cd_wd   = CD_W'(1);
			end else if (op_q == OP_REMOVE && found_q) begin
				id_we   = 1'b1;
				wr_addr = found_idx_q;
				id_wd   = '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (id_we) begin
			mem_id[wr_addr] <= id_wd;
		end
		if (per_we) begin
			mem_per[wr_addr] <= per_q;
		end
		if (cd_we) begin
			mem_cd[wr_addr] <= cd_wd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_ip_q <= '0;
			vld_cd_q <= '0;
		end else begin
			if (id_we) begin
				vld_ip_q[wr_addr] <= 1'b1;
			end
			if (cd_we) begin
				vld_cd_q[wr_addr] <= 1'b1;
			end
		end
	end

	// registered read; an entry never written reads as zero
	always_ff @(posedge clk) begin
		if (rd_go) begin
			idx_s1 <= rd_addr_q;
			id_s1  <= vld_ip_q[rd_addr_q] ? mem_id[rd_addr_q] : '0;
			per_s1 <= vld_ip_q[rd_addr_q] ? mem_per[rd_addr_q] : '0;
			cd_s1  <= vld_cd_q[rd_addr_q] ? mem_cd[rd_addr_q] : '0;
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			op_q  <= req_op;
			id_q  <= req_id;
			per_q <= req_period;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_time_q <= '0;
			rd_addr_q   <= '0;
			rd_busy_q   <= 1'b0;
			s1_v_q      <= 1'b0;
			found_q     <= 1'b0;
			free_q      <= 1'b0;
			found_idx_q <= '0;
			free_idx_q  <= '0;
			n_q         <= '0;
		end else if (cmd.cap) begin
			if (req_op == OP_POLL) begin
				last_time_q <= req_now;
			end
			rd_addr_q <= '0;
			rd_busy_q <= sts.kind_walk;
			s1_v_q    <= 1'b0;
			found_q   <= 1'b0;
			free_q    <= 1'b0;
			n_q       <= '0;
		end else if (step) begin
			s1_v_q <= rd_busy_q;
			if (rd_go) begin
				rd_addr_q <= rd_addr_q + IW'(1);
				if (rd_addr_q == LAST_IDX) begin
					rd_busy_q <= 1'b0;
				end
			end
			if (proc && !poll_q) begin
				if (!found_q && id_s1 == id_q) begin
					found_q     <= 1'b1;
					found_idx_q <= idx_s1;
				end
				if (!free_q && id_s1 == '0) begin
					free_q     <= 1'b1;
					free_idx_q <= idx_s1;
				end
			end
			if (proc && emit) begin
				n_q <= n_q + CW'(1);
			end
		end
	end

	// results leave the hold stage one behind, so the final one can carry last
	assign push_last = cmd.flush;
	assign push_v    = hold_v_q && ((proc && emit) || (cmd.flush && out_free));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
		end else if (cmd.finish && res_v) begin
			hold_v_q <= 1'b1;
		end else if (proc && emit) begin
			hold_v_q <= 1'b1;
		end else if (cmd.flush && out_free) begin
			hold_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish && res_v) begin
			hold_status_q <= res_status;
			hold_idx_q    <= res_idx;
			hold_id_q     <= res_id;
		end else if (proc && emit) begin
			hold_status_q <= ST_FIRED;
			hold_idx_q    <= idx_s1;
			hold_id_q     <= id_s1;
		end
	end

	assign hold_idx_ext = {{SLOT_W{1'b0}}, hold_idx_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (push_v) begin
			out_v_q <= 1'b1;
		end else if (rsp.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push_v) begin
			out_status_q <= hold_status_q;
			out_slot_q   <= hold_idx_ext[SLOT_W-1:0];
			out_id_q     <= hold_id_q;
			out_last_q   <= push_last;
		end
	end

	assign rsp.valid    = out_v_q;
	assign rsp.status   = out_status_q;
	assign rsp.slot     = out_slot_q;
	assign rsp.fired_id = out_id_q;
	assign rsp.last     = out_last_q;

	`PTS_ASSERT_IMP(a_cap_hold_empty, cmd.cap, !hold_v_q)
	`PTS_ASSERT_IMP(a_finish_after_sweep, cmd.finish, !rd_busy_q && !s1_v_q)
	`PTS_ASSERT_IMP(a_rw_apart, cd_we && rd_go, wr_addr != rd_addr_q)
	`PTS_ASSERT_IMP(a_fire_cap, 1'b1, n_q <= CW'(MAX_OUT))
	`PTS_ASSERT_NXT(a_result_held, cmd.finish && addrm_q, hold_v_q)

endmodule

// ===== rtl/periodic_tick_scheduler.sv =====
// ----------------------------------------------------------------------------
// periodic_tick_scheduler
// Table of periodic clients: add, remove and millisecond polls that fire
// each client whose countdown runs out, at most MAX_OUT per poll.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake      payload
//   req      in   valid / ready  op, client_id, period, now_ms
//   rsp      out  valid / ready  status, slot, fired_id, last
//
// One request is in flight at a time. A poll with a new time or an add or
// remove with a nonzero id sweeps the table one slot a cycle through the
// registered read port while rsp keeps up. A null-id request skips the
// sweep; a poll at an unchanged time or op three yields nothing.
// Reset clears the per-slot valid bits, so the table reads as empty at once.
// A stalled rsp holds the sweep only when a new fire meets a full hold stage,
// and holds the final flush until the output register frees; the next
// request is accepted while the last result still waits in rsp.
// ----------------------------------------------------------------------------
module periodic_tick_scheduler import pts_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	pts_req_if.sink   req,
	pts_res_if.source rsp
);

	pts_cmd_t cmd;
	pts_sts_t sts;

	// sequencer: decides when to take a request, sweep, resolve and flush
	pts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.sts       (sts),
		.req_ready (req.ready),
		.cmd       (cmd)
	);

	// datapath: slot table, sweep pipeline, result hold and output register
	pts_dp #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.req_op     (req.op),
		.req_id     (req.client_id),
		.req_period (req.period),
		.req_now    (req.now_ms),
		.rsp        (rsp)
	);

endmodule

// ===== dv/periodic_tick_scheduler_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// periodic_tick_scheduler_test
// Self-checking bench for the periodic tick scheduler. A queue of requests,
// directed first and then random with fill and drain phases, feeds a driver
// that idles in random bursts. A monitor predicts every result from its own
// copy of the client table and checks each result in order, while the
// result side stalls in random bursts.
// ----------------------------------------------------------------------------
module periodic_tick_scheduler_test;
	import pts_pkg::*;

	localparam int TAB_SLOTS = SLOTS_DEF;
	localparam int RANDOM_REQUESTS = 310;
	localparam int ID_POOL = 24;
	localparam int QUIET_TAIL = 40;      // requests left when idling stops
	localparam int DRAIN_CYCLES = 2 * TAB_SLOTS + 8;
	localparam int STALL_LIMIT = 2000;   // cycles with no handshake at all

	// Op three has no meaning; the block drops it.
	localparam logic [OP_W-1:0] OP_NONE = 2'd3;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [ID_W-1:0]   client_id;
		logic [PER_W-1:0]  period;
		logic [TIME_W-1:0] now_ms;
	} request_t;

	typedef struct packed {
		logic [ST_W-1:0]   status;
		logic [SLOT_W-1:0] slot;
		logic [ID_W-1:0]   fired_id;
		logic              last;
	} result_t;

	logic clk;
	logic arst_n;

	pts_req_if req_ch ();
	pts_res_if rsp_ch ();

	periodic_tick_scheduler #(.SLOTS(TAB_SLOTS)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Requests waiting to be driven, and results the table owes us.
	request_t request_queue[$];
	result_t  owed_results[$];

	// Shadow copy of the client table.
	logic [ID_W-1:0]   tab_id        [TAB_SLOTS];
	logic [PER_W-1:0]  tab_period    [TAB_SLOTS];
	logic [CD_W-1:0]   tab_countdown [TAB_SLOTS];
	logic [TIME_W-1:0] tick_last;

	int err_count;
	int accepted_cnt, add_cnt, remove_cnt, poll_cnt;
	int checked_cnt, fire_cnt, full_cnt, peak_fires;

	// Handshake bookkeeping; req_took and idle_ok pass between the edges.
	logic req_took;
	logic idle_ok;
	int   cycle_no;
	int   quiet_cycles;

	// Clock: 8 ns period.
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// ------------------------------------------------------------------------
	// Table lookup: lowest slot holding the id, or -1.
	// ------------------------------------------------------------------------
	function automatic int find_slot(input logic [ID_W-1:0] id);
		for (int i = 0; i < TAB_SLOTS; i++)
			if (tab_id[i] == id)
				return i;
		return -1;
	endfunction

	// ------------------------------------------------------------------------
	// Advance the shadow table by one accepted request and queue the
	// results it owes, the final one marked last.
	// ------------------------------------------------------------------------
	task automatic schedule_step(input request_t r);
		result_t outs[$];
		result_t one;
		int at;
		int fr;
		accepted_cnt++;
		if (r.op == OP_POLL) begin
			poll_cnt++;
			// Same millisecond as before: nothing steps, nothing fires.
			if (r.now_ms != tick_last) begin
				for (int i = 0; i < TAB_SLOTS; i++) begin
					if (tab_countdown[i] <= 1) begin
						// Empty slots reload silently; at most MAX_OUT fires report.
						if (tab_id[i] != '0 && outs.size() < MAX_OUT) begin
							one = '{ST_FIRED, SLOT_W'(i), tab_id[i], 1'b0};
							outs.push_back(one);
						end
						tab_countdown[i] = CD_W'(tab_period[i]);
					end else begin
						tab_countdown[i] = tab_countdown[i] - 1'b1;
					end
				end
				tick_last = r.now_ms;
				fire_cnt += outs.size();
				if (outs.size() > peak_fires)
					peak_fires = outs.size();
			end
		end else if (r.op == OP_ADD || r.op == OP_REMOVE) begin
			if (r.op == OP_ADD)
				add_cnt++;
			else
				remove_cnt++;
			if (r.client_id == '0) begin
				one = '{ST_NULL_ID, '0, '0, 1'b0};
			end else if (r.op == OP_ADD) begin
				at = find_slot(r.client_id);
				fr = find_slot('0);
				if (at >= 0) begin
					one = '{ST_PRESENT, SLOT_W'(at), r.client_id, 1'b0};
				end else if (fr < 0) begin
					one = '{ST_FULL, '0, r.client_id, 1'b0};
					full_cnt++;
				end else begin
					// New client fires on the next fresh tick.
					tab_id[fr] = r.client_id;
					tab_period[fr] = r.period;
					tab_countdown[fr] = CD_W'(1);
					one = '{ST_ADDED, SLOT_W'(fr), r.client_id, 1'b0};
				end
			end else begin
				at = find_slot(r.client_id);
				if (at >= 0) begin
					// Period and countdown stay; only the id is freed.
					tab_id[at] = '0;
					one = '{ST_REMOVED, SLOT_W'(at), r.client_id, 1'b0};
				end else begin
					one = '{ST_ABSENT, '0, r.client_id, 1'b0};
				end
			end
			outs.push_back(one);
		end
		if (outs.size() > 0)
			outs[outs.size() - 1].last = 1'b1;
		foreach (outs[k])
			owed_results.push_back(outs[k]);
	endtask

	task automatic queue_request(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
			input logic [PER_W-1:0] per, input logic [TIME_W-1:0] now);
		request_t r;
		r = '{op, id, per, now};
		request_queue.push_back(r);
	endtask

	// ------------------------------------------------------------------------
	// Request driver: change at the falling edge, hold until taken.
	// ------------------------------------------------------------------------
	int gap_left;

	always @(negedge clk) begin : req_driver
		request_t item;
		if (arst_n) begin
			if (req_ch.valid && !req_took) begin
				// hold the request until it is taken
			end else if (gap_left != 0) begin
				req_ch.valid <= 1'b0;
				gap_left--;
			end else if (request_queue.size() == 0) begin
				req_ch.valid <= 1'b0;
			end else if (idle_ok && $urandom_range(0, 3) == 0) begin
				// idle for a random burst
				req_ch.valid <= 1'b0;
				gap_left = $urandom_range(0, 10);
			end else begin
				item = request_queue.pop_front();
				req_ch.valid     <= 1'b1;
				req_ch.op        <= item.op;
				req_ch.client_id <= item.client_id;
				req_ch.period    <= item.period;
				req_ch.now_ms    <= item.now_ms;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Result sink: drop ready in random bursts.
	// ------------------------------------------------------------------------
	int stall_left;

	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_left != 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left--;
			end else if (idle_ok && $urandom_range(0, 5) == 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left = $urandom_range(0, 10);
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: sample at the rising edge. Check the result first, since it
	// always belongs to an earlier request, then predict the new request.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : monitor
		result_t got;
		result_t want;
		if (arst_n) begin
			cycle_no++;
			if (rsp_ch.valid && rsp_ch.ready) begin
				got = '{rsp_ch.status, rsp_ch.slot, rsp_ch.fired_id, rsp_ch.last};
				if (owed_results.size() == 0) begin
					$display("%0t: unexpected result status=%0d slot=%0d id=%h last=%b",
						$time, got.status, got.slot, got.fired_id, got.last);
					err_count++;
				end else begin
					want = owed_results.pop_front();
					checked_cnt++;
					if (got.status !== want.status || got.slot !== want.slot ||
							got.fired_id !== want.fired_id || got.last !== want.last) begin
						$display("%0t: result mismatch: expected status=%0d slot=%0d id=%h last=%b",
							$time, want.status, want.slot, want.fired_id, want.last);
						$display("%0t: result mismatch: actual   status=%0d slot=%0d id=%h last=%b",
							$time, got.status, got.slot, got.fired_id, got.last);
						err_count++;
					end
				end
			end
			if (req_ch.valid && req_ch.ready)
				schedule_step('{req_ch.op, req_ch.client_id, req_ch.period,
					req_ch.now_ms});
		end
		req_took <= arst_n && req_ch.valid && req_ch.ready;
		// Idle only outside the quiet tail, with idle-free stretches between.
		idle_ok  <= request_queue.size() >= QUIET_TAIL && (cycle_no % 600) < 450;
	end

	// ------------------------------------------------------------------------
	// Watchdog: count cycles with no handshake on either channel.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles == STALL_LIMIT) begin
				$display("%0t: no handshake for %0d cycles, %0d results still owed",
					$time, STALL_LIMIT, owed_results.size());
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus and end of run.
	// ------------------------------------------------------------------------
	initial begin
		logic [ID_W-1:0]   id_pool [ID_POOL];
		logic [TIME_W-1:0] now_gen;
		logic [OP_W-1:0]   op;
		logic [ID_W-1:0]   id;
		logic [PER_W-1:0]  per;
		logic [TIME_W-1:0] now;
		int counted;
		int r;
		bit drain;

		// Every input known from time zero; reset held.
		arst_n           = 1'b0;
		req_ch.valid     = 1'b0;
		req_ch.op        = OP_POLL;
		req_ch.client_id = '0;
		req_ch.period    = '0;
		req_ch.now_ms    = '0;
		rsp_ch.ready     = 1'b0;
		req_took         = 1'b0;
		idle_ok          = 1'b0;
		gap_left         = 0;
		stall_left       = 0;
		cycle_no         = 0;
		quiet_cycles     = 0;
		err_count        = 0;
		accepted_cnt     = 0;
		add_cnt          = 0;
		remove_cnt       = 0;
		poll_cnt         = 0;
		checked_cnt      = 0;
		fire_cnt         = 0;
		full_cnt         = 0;
		peak_fires       = 0;
		for (int i = 0; i < TAB_SLOTS; i++) begin
			tab_id[i]        = '0;
			tab_period[i]    = '0;
			tab_countdown[i] = '0;
		end
		tick_last = '0;

		// Directed: null ids, op three, same-time poll, period zero and
		// one and maximum, duplicate add, time wrap, remove present and
		// absent, then fill the table past full and poll it.
		queue_request(OP_ADD, '0, 16'h1234, '0);
		queue_request(OP_REMOVE, '0, '0, '0);
		queue_request(OP_NONE, 16'h55AA, 16'h0003, 32'h0000_0007);
		queue_request(OP_POLL, '0, '0, '0);
		queue_request(OP_ADD, 16'hFFFF, 16'h0000, '0);
		queue_request(OP_ADD, 16'h0001, 16'h0001, '0);
		queue_request(OP_ADD, 16'hFFFF, 16'h0002, '0);
		queue_request(OP_ADD, 16'h8000, 16'hFFFF, '0);
		queue_request(OP_POLL, '0, '0, 32'd1);
		queue_request(OP_POLL, 16'hFFFF, 16'hFFFF, 32'd1);
		queue_request(OP_POLL, '0, '0, 32'hFFFF_FFFF);
		queue_request(OP_REMOVE, 16'h0001, '0, '0);
		queue_request(OP_REMOVE, 16'h0001, '0, '0);
		for (int k = 0; k < TAB_SLOTS - 1; k++)
			queue_request(OP_ADD, ID_W'(16'h0100 + k), PER_W'(k % 3), '0);
		queue_request(OP_POLL, '0, '0, 32'd0);
		now_gen = '0;

		// Random: alternate drain and fill phases over a small id pool so
		// that duplicates, absent ids and a full table keep turning up.
		foreach (id_pool[i])
			id_pool[i] = ID_W'($urandom_range(1, 65535));
		counted = 0;
		while (counted < RANDOM_REQUESTS) begin
			drain = ((counted / 60) % 2) == 0;
			r = $urandom_range(0, 99);
			if (r < 4)
				op = OP_NONE;
			else if (r < 40)
				op = OP_POLL;
			else if (r < (drain ? 55 : 85))
				op = OP_ADD;
			else
				op = OP_REMOVE;
			id = ($urandom_range(0, 29) == 0) ? '0 : id_pool[$urandom_range(0, ID_POOL - 1)];
			r = $urandom_range(0, 9);
			if (r < 6)
				per = PER_W'($urandom_range(0, 4));
			else if (r < 8)
				per = PER_W'($urandom_range(5, 40));
			else
				per = PER_W'($urandom());
			r = $urandom_range(0, 99);
			if (r < 70)
				now = now_gen + 1;
			else if (r < 78)
				now = now_gen;
			else if (r < 90)
				now = now_gen + $urandom_range(2, 1000);
			else
				now = $urandom();
			if (op == OP_POLL) begin
				if (now != now_gen)
					counted++;
				now_gen = now;
			end else if (op != OP_NONE) begin
				counted++;
			end
			queue_request(op, id, per, now);
		end

		// Release reset away from the rising edge.
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait for every request to go in and every owed result to come out.
		while (request_queue.size() != 0 || req_ch.valid || owed_results.size() != 0)
			@(posedge clk);
		// Let the last sweep finish so a stray result gets caught.
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d requests: %0d adds, %0d removes, %0d polls.",
			accepted_cnt, add_cnt, remove_cnt, poll_cnt);
		$display("Checked %0d results: %0d fires (up to %0d in one poll), %0d refusals.",
			checked_cnt, fire_cnt, peak_fires, full_cnt);
		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
